/* rtl/sse_pkg.sv */
// ----------------------------------------------------------------------------
// sse_pkg: shared constants and types of the subset sum enumerator
// Widths, codes and the beat structures passed between the top level and
// the enumeration engine.
// ----------------------------------------------------------------------------
package sse_pkg;

  // Storage depth of the value list and of the position list
  localparam int MAX_LEN = 16;

  // Field widths fixed by the item format
  localparam int KIND_W    = 2;
  localparam int LIDX_W    = 5;
  localparam int VAL_W     = 16;
  localparam int SUM_W     = 20;
  localparam int MASK_W    = 16;
  localparam int REG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Position numbers wrap modulo 64
  localparam int POS_W = 6;

  // Derived widths
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int ACC_W = VAL_W + $clog2(MAX_LEN) + 1;

  // Saturation limits of the reported sum
  localparam int SUM_MAX = 524287;
  localparam int SUM_MIN = -524288;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_LENGTH = 1'd1;

  // Request beat towards the engine
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [LIDX_W-1:0]       load_index;
    logic signed [VAL_W-1:0] load_value;
  } sse_req_t;

  // Current configuration
  typedef struct packed {
    logic [REG_W-1:0] subset_size;
    logic [REG_W-1:0] list_length;
  } sse_cfg_t;

  // Result beat from the engine
  typedef struct packed {
    logic                    valid_res;
    logic signed [SUM_W-1:0] subset_sum;
    logic [MASK_W-1:0]       member_mask;
    logic                    sign_negative;
    logic                    is_final;
  } sse_res_t;

endpackage

/* rtl/sse_in_if.sv */
// ----------------------------------------------------------------------------
// sse_in_if: input item channel
// Valid/ready channel carrying one load, start or next item per beat.
// ----------------------------------------------------------------------------
interface sse_in_if;
  logic                                valid;
  logic                                ready;
  logic [sse_pkg::KIND_W-1:0]          kind;
  logic [sse_pkg::LIDX_W-1:0]          load_index;
  logic signed [sse_pkg::VAL_W-1:0]    load_value;

  modport source (output valid, output kind, output load_index, output load_value,
                  input ready);
  modport sink   (input valid, input kind, input load_index, input load_value,
                  output ready);
endinterface

/* rtl/sse_out_if.sv */
// ----------------------------------------------------------------------------
// sse_out_if: result channel
// Valid/ready channel carrying one subset report per beat.
// ----------------------------------------------------------------------------
interface sse_out_if;
  logic                                valid;
  logic                                ready;
  logic                                valid_res;
  logic signed [sse_pkg::SUM_W-1:0]    subset_sum;
  logic [sse_pkg::MASK_W-1:0]          member_mask;
  logic                                sign_negative;
  logic                                is_final;

  modport source (output valid, output valid_res, output subset_sum,
                  output member_mask, output sign_negative, output is_final,
                  input ready);
  modport sink   (input valid, input valid_res, input subset_sum,
                  input member_mask, input sign_negative, input is_final,
                  output ready);
endinterface

/* rtl/sse_cfg_if.sv */
// ----------------------------------------------------------------------------
// sse_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface sse_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sse_pkg::CFG_IDX_W-1:0]       index;
  logic [sse_pkg::REG_W-1:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sse_engine.sv */
// ----------------------------------------------------------------------------
// sse_engine: value store, position list and enumeration sequencer
// Sums the current subset one position per cycle through a single
// accumulator, then steps the position list to the next subset, refilling
// the tail one position per cycle.
// ----------------------------------------------------------------------------
module sse_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  sse_pkg::sse_req_t req_i,
  input  sse_pkg::sse_cfg_t cfg_i,
  output logic              res_valid_o,
  input  logic              res_take_i,
  output sse_pkg::sse_res_t res_o
);

  localparam int POS_W = sse_pkg::POS_W;
  localparam int IDX_W = sse_pkg::IDX_W;
  localparam int CNT_W = sse_pkg::CNT_W;
  localparam int ACC_W = sse_pkg::ACC_W;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(sse_pkg::SUM_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(sse_pkg::SUM_MIN);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_ADV  = 3'd2;
  localparam logic [2:0] ST_FILL = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]                      state_q, state_d;
  logic [POS_W-1:0]                pos_q [sse_pkg::MAX_LEN];
  logic signed [sse_pkg::VAL_W-1:0] store_q [sse_pkg::MAX_LEN];
  logic [CNT_W-1:0]                active_q, active_d;
  logic                            sign_q, sign_d;
  logic                            exhausted_q, exhausted_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [POS_W-1:0]                fill_q, fill_d;
  logic signed [ACC_W-1:0]         acc_q, acc_d;
  logic [sse_pkg::MASK_W-1:0]      mask_q, mask_d;
  logic                            res_ok_q, res_ok_d;
  logic                            res_sign_q, res_sign_d;
  logic                            res_final_q, res_final_d;

  logic                            accept;
  logic                            store_we;
  logic                            start_en;
  logic                            pos_we;
  logic [IDX_W-1:0]                pos_wr_idx;
  logic [POS_W-1:0]                pos_wr_val;
  logic [POS_W-1:0]                n_len, p_len, p_start, aa, cnt_ext;
  logic [POS_W-1:0]                limit, tail;
  logic [IDX_W-1:0]                rd_idx;
  logic [POS_W-1:0]                rd_pos, inc_pos;
  logic                            pos_in_range;
  logic signed [sse_pkg::VAL_W-1:0] rd_val;
  logic signed [sse_pkg::SUM_W-1:0] sum_sat;

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_HOLD);

  // Clamp the configuration to the storage depth
  assign n_len   = (cfg_i.list_length > sse_pkg::MAX_LEN) ?
                   POS_W'(sse_pkg::MAX_LEN) : POS_W'(cfg_i.list_length);
  assign p_len   = POS_W'(cfg_i.subset_size);
  assign p_start = (cfg_i.subset_size > sse_pkg::MAX_LEN) ?
                   POS_W'(sse_pkg::MAX_LEN) : p_len;
  assign aa      = POS_W'(active_q);
  assign cnt_ext = POS_W'(cnt_q);
  assign limit   = n_len - p_len + aa;
  assign tail    = p_len - aa;

  // Single read port on the position list, then on the value store
  assign rd_idx       = (state_q == ST_ADV) ? IDX_W'(aa - 1'b1) : cnt_q[IDX_W-1:0];
  assign rd_pos       = pos_q[rd_idx];
  assign inc_pos      = rd_pos + 1'b1;
  assign pos_in_range = (rd_pos != '0) && (rd_pos <= n_len);
  assign rd_val       = store_q[IDX_W'(rd_pos - 1'b1)];

  assign store_we = accept && (req_i.kind == sse_pkg::KIND_LOAD) &&
                    (req_i.load_index != '0) && (req_i.load_index <= sse_pkg::MAX_LEN);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    sign_d      = sign_q;
    exhausted_d = exhausted_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    acc_d       = acc_q;
    mask_d      = mask_q;
    res_ok_d    = res_ok_q;
    res_sign_d  = res_sign_q;
    res_final_d = res_final_q;
    start_en    = 1'b0;
    pos_we      = 1'b0;
    pos_wr_idx  = rd_idx;
    pos_wr_val  = inc_pos;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            sse_pkg::KIND_START: begin
              start_en    = 1'b1;
              sign_d      = 1'b0;
              exhausted_d = 1'b0;
              active_d    = (p_start == n_len) ? '0 : CNT_W'(p_start);
            end
            sse_pkg::KIND_NEXT: begin
              cnt_d       = '0;
              acc_d       = '0;
              mask_d      = '0;
              if (exhausted_q || (p_len > n_len)) begin
                res_ok_d    = 1'b0;
                res_sign_d  = 1'b0;
                res_final_d = 1'b0;
                state_d     = ST_HOLD;
              end else begin
                res_ok_d    = 1'b1;
                res_sign_d  = sign_q;
                res_final_d = (active_q == '0);
                state_d     = (p_len == '0) ? ST_ADV : ST_SUM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SUM: begin
        // Add one member per cycle
        if (pos_in_range) begin
          acc_d  = acc_q + ACC_W'(rd_val);
          mask_d = mask_q | (sse_pkg::MASK_W'(1) << (rd_pos - 1'b1));
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_ext + 1'b1 == p_len) begin
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        // Bump the active position and decide whether the tail is rebuilt
        if ((aa == '0) || (aa > p_len)) begin
          exhausted_d = 1'b1;
          state_d     = ST_HOLD;
        end else begin
          pos_we = 1'b1;
          if (inc_pos == limit) begin
            active_d = active_q - 1'b1;
            sign_d   = ~sign_q;
            state_d  = ST_HOLD;
          end else begin
            sign_d   = sign_q ^ (~tail[0] | (n_len[0] ^ inc_pos[0]));
            active_d = CNT_W'(p_len);
            fill_d   = inc_pos;
            cnt_d    = active_q;
            state_d  = (tail == '0) ? ST_HOLD : ST_FILL;
          end
        end
      end
      ST_FILL: begin
        // Rebuild the tail one position per cycle
        pos_we     = 1'b1;
        pos_wr_idx = cnt_q[IDX_W-1:0];
        pos_wr_val = fill_q + 1'b1;
        fill_d     = fill_q + 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_ext + 1'b1 == p_len) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      sign_q      <= 1'b0;
      exhausted_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      sign_q      <= sign_d;
      exhausted_q <= exhausted_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    fill_q      <= fill_d;
    acc_q       <= acc_d;
    mask_q      <= mask_d;
    res_ok_q    <= res_ok_d;
    res_sign_q  <= res_sign_d;
    res_final_q <= res_final_d;
  end

  // Position list: parallel preset on start, single write otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sse_pkg::MAX_LEN; i++) begin
        pos_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < sse_pkg::MAX_LEN; i++) begin
        if (start_en && (POS_W'(i) < p_start)) begin
          pos_q[i] <= POS_W'(i + 1);
        end else if (pos_we && (pos_wr_idx == IDX_W'(i))) begin
          pos_q[i] <= pos_wr_val;
        end
      end
    end
  end

  // Value store
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[IDX_W'(req_i.load_index - 1'b1)] <= req_i.load_value;
    end
  end

  // Saturate the accumulated sum to the reported width
  always_comb begin
    if (acc_q > SAT_HI) begin
      sum_sat = sse_pkg::SUM_W'(SAT_HI);
    end else if (acc_q < SAT_LO) begin
      sum_sat = sse_pkg::SUM_W'(SAT_LO);
    end else begin
      sum_sat = sse_pkg::SUM_W'(acc_q);
    end
  end

  assign res_o.valid_res     = res_ok_q;
  assign res_o.subset_sum    = sum_sat;
  assign res_o.member_mask   = mask_q;
  assign res_o.sign_negative = res_sign_q;
  assign res_o.is_final      = res_final_q;

  // Summation never runs past the subset size
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (cnt_ext < p_len))
    else $error("summation index past subset size");

  // A start always re-arms the enumeration
  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.kind == sse_pkg::KIND_START)) |=> !exhausted_q)
    else $error("start did not clear exhausted flag");

  // An empty report carries zero fields
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.valid_res) |->
      ((res_o.subset_sum == '0) && (res_o.member_mask == '0) &&
       !res_o.sign_negative && !res_o.is_final))
    else $error("empty report with non-zero fields");

  // Active index stays within the position list
  a_active_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aa <= POS_W'(sse_pkg::MAX_LEN))
    else $error("active index beyond list depth");

  // A held result waits until it is taken
  a_hold_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_take_i) |=> res_valid_o)
    else $error("held result dropped");

endmodule

/* rtl/subset_sum_enumerator.sv */
// ----------------------------------------------------------------------------
// subset_sum_enumerator: lexicographic p-subset generator with subset sums
// Stores up to sixteen signed values and walks the p-subsets of the first
// n positions in lexicographic order, reporting sum, mask, sign and end flag.
//
//   channel  dir  beat contents
//   in_i     in   kind, load_index, load_value
//   out_o    out  valid_res, subset_sum, member_mask, sign_negative, is_final
//   cfg_i    in   index (0 subset_size, 1 list_length), data
//
// Load and start items are taken while idle and may follow every cycle.
// A next item is taken, its p positions are summed through the one
// accumulator, the active position is stepped and the p - a tail positions
// are refilled when the tail is rebuilt (a the active index, at least 1 when
// a refill happens), then the report is handed over.
// Input stays not ready while a next item is in work; a finished report
// sits in the output register while the next item is taken.
// Reset clears positions, flags and the output valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module subset_sum_enumerator (
  input  logic      clk_i,
  input  logic      rst_ni,
  sse_in_if.sink    in_i,
  sse_out_if.source out_o,
  sse_cfg_if.sink   cfg_i
);

  logic [sse_pkg::REG_W-1:0] subset_size_q;
  logic [sse_pkg::REG_W-1:0] list_length_q;
  logic                      out_valid_q;
  sse_pkg::sse_res_t         out_res_q;

  sse_pkg::sse_req_t         req;
  sse_pkg::sse_cfg_t         cfg;
  sse_pkg::sse_res_t         res;
  logic                      res_valid;
  logic                      res_take;
  logic                      req_ready;

  assign req.kind       = in_i.kind;
  assign req.load_index = in_i.load_index;
  assign req.load_value = in_i.load_value;
  assign in_i.ready     = req_ready;

  assign cfg.subset_size = subset_size_q;
  assign cfg.list_length = list_length_q;

  sse_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subset_size_q <= sse_pkg::REG_W'(1);
      list_length_q <= sse_pkg::REG_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sse_pkg::CFG_SUBSET_SIZE: subset_size_q <= cfg_i.data;
        sse_pkg::CFG_LIST_LENGTH: list_length_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Move a finished report into the output register once it is free
  assign res_take = res_valid && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.valid_res     = out_res_q.valid_res;
  assign out_o.subset_sum    = out_res_q.subset_sum;
  assign out_o.member_mask   = out_res_q.member_mask;
  assign out_o.sign_negative = out_res_q.sign_negative;
  assign out_o.is_final      = out_res_q.is_final;

endmodule

/* sim/subset_sum_enumerator_tb.sv */
// ----------------------------------------------------------------------------
// subset_sum_enumerator_tb: self-checking bench for the subset sum enumerator
// Drives load, start and next beats plus register writes, predicts every
// report with a cycle-free model of the lexicographic subset walk (sum, mask,
// running sign, end flag) and compares each result beat field by field.
// Directed corner tests come first, then random walks under three idling
// mixes, with one long output stall to fill the block and stall its input.
// ----------------------------------------------------------------------------
module subset_sum_enumerator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN   = sse_pkg::MAX_LEN;
  localparam int KIND_W    = sse_pkg::KIND_W;
  localparam int LIDX_W    = sse_pkg::LIDX_W;
  localparam int VAL_W     = sse_pkg::VAL_W;
  localparam int SUM_W     = sse_pkg::SUM_W;
  localparam int MASK_W    = sse_pkg::MASK_W;
  localparam int REG_W     = sse_pkg::REG_W;
  localparam int CFG_IDX_W = sse_pkg::CFG_IDX_W;
  localparam int POS_W     = sse_pkg::POS_W;
  localparam int SUM_MAX   = sse_pkg::SUM_MAX;
  localparam int SUM_MIN   = sse_pkg::SUM_MIN;

  localparam int HALF_PERIOD   = 5;
  localparam int MAX_GAP       = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 2 * MAX_LEN + 8;
  localparam int MAX_REPORTS   = 10;
  localparam int WALK_CAP      = 40;
  localparam longint LIMIT_NS  = 64'd5_000_000;

  // Kind code outside the defined set: the block must drop it
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  sse_in_if  in_if ();
  sse_out_if out_if ();
  sse_cfg_if cfg_if ();

  subset_sum_enumerator dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Idling mix, long stall request and bookkeeping
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned fault_cnt;
  int          items_left;

  // Predicted state of the walk
  logic signed [VAL_W-1:0] val_mem [MAX_LEN];
  logic [POS_W-1:0]        pos_mem [MAX_LEN];
  int unsigned             act_idx;
  logic                    sign_q;
  logic                    done_q;
  logic [REG_W-1:0]        size_reg;
  logic [REG_W-1:0]        len_reg;
  sse_pkg::sse_res_t       report_q [$];

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------- predictor

  task automatic model_reset();
    for (int i = 0; i < MAX_LEN; i++) begin
      val_mem[i] = '0;
      pos_mem[i] = '0;
    end
    act_idx  = 0;
    sign_q   = 1'b0;
    done_q   = 1'b1;
    size_reg = REG_W'(1);
    len_reg  = REG_W'(1);
  endtask

  function automatic int unsigned list_len();
    return (len_reg > MAX_LEN) ? MAX_LEN : int'(len_reg);
  endfunction

  task automatic model_config(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    if (idx == sse_pkg::CFG_SUBSET_SIZE) size_reg = data;
    else len_reg = data;
  endtask

  // Put the walk on {1..p}, sign plus one
  task automatic model_start();
    int unsigned n;
    int unsigned p;
    n = list_len();
    p = (size_reg > MAX_LEN) ? MAX_LEN : int'(size_reg);
    sign_q = 1'b0;
    for (int unsigned i = 1; i <= p; i++) pos_mem[i-1] = POS_W'(i);
    act_idx = (p == n) ? 0 : p;
    done_q = 1'b0;
  endtask

  // Advance to the next p-subset; flip the sign by the parity of the change
  task automatic model_advance(input int unsigned p, input int unsigned n);
    int unsigned aa;
    logic [POS_W-1:0] t;
    aa = act_idx;
    if (aa == 0 || aa > p) begin
      done_q = 1'b1;
      return;
    end
    t = pos_mem[aa-1] + 1'b1;
    pos_mem[aa-1] = t;
    if (int'(t) == n - p + aa) begin
      aa--;
      sign_q = ~sign_q;
    end else begin
      for (int unsigned i = 1; i <= p - aa; i++) pos_mem[aa+i-1] = POS_W'(t + i);
      if (((p - aa) & 1) == 0 || ((n - t) & 1) == 1) sign_q = ~sign_q;
      aa = p;
    end
    act_idx = aa;
  endtask

  // Form the report of the current subset, then advance
  task automatic model_next(output sse_pkg::sse_res_t r);
    int unsigned n;
    int unsigned p;
    int acc;
    logic [MASK_W-1:0] m;
    n = list_len();
    p = size_reg;
    r = '0;
    if (done_q || p > n) return;
    acc = 0;
    m = '0;
    for (int unsigned i = 1; i <= p; i++) begin
      if (pos_mem[i-1] >= 1 && pos_mem[i-1] <= n) begin
        acc += val_mem[pos_mem[i-1] - 1];
        m[pos_mem[i-1] - 1] = 1'b1;
      end
    end
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    r.valid_res     = 1'b1;
    r.subset_sum    = acc[SUM_W-1:0];
    r.member_mask   = m;
    r.sign_negative = sign_q;
    r.is_final      = (act_idx == 0);
    model_advance(p, n);
  endtask

  task automatic model_item(input logic [KIND_W-1:0] kind, input logic [LIDX_W-1:0] idx,
                            input logic signed [VAL_W-1:0] val);
    sse_pkg::sse_res_t r;
    case (kind)
      sse_pkg::KIND_LOAD: begin
        if (idx >= 1 && idx <= MAX_LEN) val_mem[idx-1] = val;
      end
      sse_pkg::KIND_START: model_start();
      sse_pkg::KIND_NEXT: begin
        model_next(r);
        report_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned subset_count(input int unsigned n, input int unsigned p);
    longint unsigned c;
    if (n > MAX_LEN) n = MAX_LEN;
    if (p > n) return 0;
    c = 1;
    for (int unsigned i = 1; i <= p; i++) c = c * (n - p + i) / i;
    return int'(c);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // ------------------------------------------------------------------ drivers

  // Offer one beat after a random gap; leave valid high on return
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [LIDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.load_index <= idx;
    in_if.load_value <= val;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    model_item(kind, idx, val);
    @(negedge clk);
  endtask

  task automatic store_value(input int unsigned idx, input logic signed [VAL_W-1:0] val);
    send_item(sse_pkg::KIND_LOAD, LIDX_W'(idx), val);
  endtask

  task automatic start_walk();
    send_item(sse_pkg::KIND_START, LIDX_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic emit_next();
    send_item(sse_pkg::KIND_NEXT, LIDX_W'($urandom), VAL_W'($urandom));
  endtask

  // Beats the block must drop: unused kind, or a load outside 1..MAX_LEN
  task automatic send_noise();
    if ($urandom_range(1))
      send_item(KIND_IGNORED, LIDX_W'($urandom), VAL_W'($urandom));
    else
      send_item(sse_pkg::KIND_LOAD,
                $urandom_range(1) ? LIDX_W'(0) : LIDX_W'($urandom_range(17, 31)),
                VAL_W'($urandom));
  endtask

  // Drop valid, drain every expected report, then let the block settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write both registers in random order
  task automatic set_config(input int unsigned p, input int unsigned n);
    logic [CFG_IDX_W-1:0] idx;
    logic [REG_W-1:0] data;
    bit swap;
    swap = $urandom_range(1);
    for (int k = 0; k < 2; k++) begin
      idx  = ((k == 0) != swap) ? sse_pkg::CFG_SUBSET_SIZE : sse_pkg::CFG_LIST_LENGTH;
      data = (idx == sse_pkg::CFG_SUBSET_SIZE) ? REG_W'(p) : REG_W'(n);
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= data;
      do @(posedge clk); while (cfg_if.ready !== 1'b1);
      model_config(idx, data);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    sse_pkg::sse_res_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (report_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS)
          $display("%0t: result beat with none expected: valid=%0b sum=%0d mask=%04h",
                   $realtime, out_if.valid_res, out_if.subset_sum, out_if.member_mask);
      end else begin
        want = report_q.pop_front();
        if (out_if.valid_res !== want.valid_res || out_if.subset_sum !== want.subset_sum ||
            out_if.member_mask !== want.member_mask ||
            out_if.sign_negative !== want.sign_negative ||
            out_if.is_final !== want.is_final) begin
          fault_cnt++;
          if (fault_cnt <= MAX_REPORTS) begin
            $display("%0t: mismatch: expected valid=%0b sum=%0d mask=%04h neg=%0b end=%0b",
                     $realtime, want.valid_res, want.subset_sum, want.member_mask,
                     want.sign_negative, want.is_final);
            $display("%0t:           got valid=%0b sum=%0d mask=%04h neg=%0b end=%0b",
                     $realtime, out_if.valid_res, out_if.subset_sum, out_if.member_mask,
                     out_if.sign_negative, out_if.is_final);
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------- tests

  // Next before any start, a dropped kind, then the largest possible sum
  task automatic test_idle_and_max();
    emit_next();
    send_item(KIND_IGNORED, '1, '1);
    for (int i = 1; i <= MAX_LEN; i++) store_value(i, 16'h7FFF);
    wait_idle();
    set_config(16, 16);
    start_walk();
    emit_next();
    emit_next();
  endtask

  // Out-of-range loads are dropped; then the smallest possible sum
  task automatic test_sum_floor();
    store_value(0, 16'h1234);
    store_value(17, 16'h4321);
    store_value(31, 16'h5555);
    for (int i = 1; i <= MAX_LEN; i++) store_value(i, 16'h8000);
    start_walk();
    emit_next();
    emit_next();
  endtask

  // Empty subset, size above length, length above the store, restart
  task automatic test_corner_sizes();
    for (int i = 1; i <= MAX_LEN; i++) store_value(i, pick_value());
    wait_idle();
    set_config(0, 0);
    start_walk();
    emit_next();
    emit_next();
    wait_idle();
    set_config(5, 3);
    start_walk();
    emit_next();
    wait_idle();
    set_config(31, 31);
    start_walk();
    emit_next();
    wait_idle();
    set_config(0, 16);
    start_walk();
    emit_next();
    emit_next();
    wait_idle();
    set_config(1, 31);
    start_walk();
    repeat (17) emit_next();
    wait_idle();
    set_config(2, 4);
    start_walk();
    emit_next();
    emit_next();
    start_walk();
    repeat (7) emit_next();
  endtask

  // Change the registers part way through a walk
  task automatic test_reconfig_midway();
    wait_idle();
    set_config(3, 6);
    start_walk();
    repeat (4) emit_next();
    wait_idle();
    set_config(2, 6);
    repeat (4) emit_next();
    wait_idle();
    set_config(4, 5);
    repeat (4) emit_next();
    wait_idle();
    set_config(3, 2);
    emit_next();
    wait_idle();
    set_config(3, 6);
    repeat (3) emit_next();
  endtask

  // Hold the output for a long stretch while items keep coming
  task automatic test_backpressure();
    wait_idle();
    set_config(3, 6);
    start_walk();
    hold_req = 1'b1;
    repeat (21) emit_next();
    wait_idle();
  endtask

  // One random walk: configure, load a few values, start, step with noise
  task automatic run_episode();
    int unsigned n;
    int unsigned p;
    int unsigned walk;
    int unsigned roll;
    case ($urandom_range(9))
      0: begin
        n = MAX_LEN;
        p = $urandom_range(1) ? $urandom_range(0, 2) : $urandom_range(14, 16);
      end
      1: begin
        n = $urandom_range(17, 31);
        p = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(15, 16);
      end
      2: begin
        n = $urandom_range(0, 15);
        p = $urandom_range(n + 1, 31);
      end
      default: begin
        n = $urandom_range(1, 7);
        p = $urandom_range(0, n);
      end
    endcase
    walk = subset_count(n, p);
    walk = (walk == 0) ? $urandom_range(1, 3) : walk + $urandom_range(0, 2);
    if (walk > WALK_CAP) walk = WALK_CAP;
    wait_idle();
    set_config(p, n);
    repeat ($urandom_range(0, 3)) begin
      store_value($urandom_range(1, MAX_LEN), pick_value());
      items_left--;
    end
    start_walk();
    items_left--;
    for (int unsigned k = 0; k < walk; k++) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        send_noise();
      end else if (roll < 14) begin
        store_value($urandom_range(1, MAX_LEN), pick_value());
        items_left--;
      end else if (roll < 16) begin
        start_walk();
        items_left--;
      end else if (roll < 18) begin
        wait_idle();
        set_config($urandom_range(0, 8), $urandom_range(0, 16));
      end
      emit_next();
      items_left--;
    end
  endtask

  task automatic test_random_traffic(input int count);
    items_left = count;
    while (items_left > 0) run_episode();
    wait_idle();
  endtask

  // --------------------------------------------------------------- sequencing

  initial begin
    in_if.valid      = 1'b0;
    in_if.kind       = sse_pkg::KIND_LOAD;
    in_if.load_index = '0;
    in_if.load_value = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = sse_pkg::CFG_SUBSET_SIZE;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
    hold_req         = 1'b0;
    hold_left        = 0;
    fault_cnt        = 0;
    send_idle_pct    = 26;
    recv_idle_pct    = 62;
    rst_n            = 1'b0;
    model_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_idle_and_max();
    test_sum_floor();
    test_corner_sizes();
    test_reconfig_midway();
    test_random_traffic(170);

    send_idle_pct = 62;
    recv_idle_pct = 26;
    test_backpressure();
    test_random_traffic(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(160);

    if (fault_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
